FILE: design/usan_pkg.sv
// ----------------------------------------------------------------------------
// usan_pkg
// Shared types and constants for the URL path sanitizer.
// ----------------------------------------------------------------------------
package usan_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ROOT_LEN_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_WORD_0 = 3'd1;

    localparam logic [7:0] C_SLASH   = 8'h2F;
    localparam logic [7:0] C_DOT     = 8'h2E;
    localparam logic [7:0] C_SAFE_LO = 8'h21;
    localparam logic [7:0] C_SAFE_HI = 8'h7E;

    localparam logic [1:0] RSN_OK      = 2'd0;
    localparam logic [1:0] RSN_UNSAFE  = 2'd1;
    localparam logic [1:0] RSN_DOTDOT  = 2'd2;
    localparam logic [1:0] RSN_OUTSIDE = 2'd3;

    typedef struct packed {
        logic [7:0] path_char;
        logic       no_char;
        logic       last_char;
    } t_item;

endpackage

FILE: design/url_path_sanitizer.sv
// ----------------------------------------------------------------------------
// url_path_sanitizer
// Streams a request path one byte per item and gives one accept or reject
// verdict on the last item, checking the normalized path against a root.
//
//   Port group   Direction  Handshake                 Payload
//   input        in         i_in_valid / o_in_stall   path_char, no_char, last_char
//   output       out        o_out_valid / i_out_stall path_ok, reject_reason
//   config       in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item is taken every clock unless o_in_stall is high; the verdict of the last
// item passes the input register and then the result register before it appears.
// Reset restores the root to "/" and clears the path state.
// While a verdict waits under stall, non-final items keep flowing; a final
// item waits in the input register until the result register frees up.
// ----------------------------------------------------------------------------
module url_path_sanitizer #(
    parameter int ROOT_MAX_BYTES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_path_char,
    input  logic                             i_no_char,
    input  logic                             i_last_char,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_path_ok,
    output logic [1:0]                       o_reject_reason,
    input  logic                             i_cfg_we,
    input  logic [usan_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [usan_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import usan_pkg::*;

    localparam int CW = $clog2(ROOT_MAX_BYTES + 2);

    logic [ROOT_LEN_W-1:0]             r_root_len;
    logic [ROOT_MAX_BYTES-1:0][7:0]    r_root;
    logic [CW-1:0]                     eff_len;

    t_item      r_item;
    logic       r_item_valid;
    logic       s1_fire;
    logic       in_accept;
    logic       out_take;
    logic [1:0] reason;
    logic       r_out_valid;
    logic       r_path_ok;
    logic [1:0] r_reason;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_len <= ROOT_LEN_W'(1);
        end else if (i_cfg_we && i_cfg_index == REG_ROOT_LENGTH) begin
            r_root_len <= i_cfg_data[ROOT_LEN_W-1:0];
        end
    end

    for (genvar g = 0; g < ROOT_MAX_BYTES; g++) begin : g_root
        localparam int WORD = g / 8;
        localparam int LANE = g % 8;
        localparam logic [7:0] RESET_VAL = (g == 0) ? C_SLASH : 8'h00;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_root[g] <= RESET_VAL;
            end else if (i_cfg_we &&
                         i_cfg_index == REG_ROOT_WORD_0 + CFG_IDX_W'(WORD)) begin
                r_root[g] <= i_cfg_data[LANE*8 +: 8];
            end
        end
    end

    assign eff_len = (r_root_len > ROOT_LEN_W'(ROOT_MAX_BYTES)) ?
                     CW'(ROOT_MAX_BYTES) : r_root_len[CW-1:0];

    assign s1_fire    = r_item_valid &&
                        (!r_item.last_char || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_item_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_accept) begin
            r_item_valid <= 1'b1;
        end else if (s1_fire) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.path_char <= i_path_char;
            r_item.no_char   <= i_no_char;
            r_item.last_char <= i_last_char;
        end
    end

    usan_norm #(
        .ROOT_MAX_BYTES (ROOT_MAX_BYTES),
        .CW             (CW)
    ) u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (s1_fire),
        .i_item     (r_item),
        .i_root_len (eff_len),
        .i_root     (r_root),
        .o_reason   (reason)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_item.last_char) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_item.last_char) begin
            r_path_ok <= (reason == RSN_OK);
            r_reason  <= reason;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_path_ok       = r_path_ok;
    assign o_reject_reason = r_reason;

endmodule

FILE: design/usan_norm.sv
// ----------------------------------------------------------------------------
// usan_norm
// Running path state: normalizes one byte per step, compares the normalized
// bytes with the document root and forms the verdict on the last item.
// ----------------------------------------------------------------------------
module usan_norm #(
    parameter int ROOT_MAX_BYTES = 32,
    parameter int CW             = $clog2(ROOT_MAX_BYTES + 2)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  usan_pkg::t_item                     i_item,
    input  logic [CW-1:0]                       i_root_len,
    input  logic [ROOT_MAX_BYTES-1:0][7:0]      i_root,
    output logic [1:0]                          o_reason
);
    import usan_pkg::*;

    localparam int IW = $clog2(ROOT_MAX_BYTES);

    typedef struct packed {
        logic [CW-1:0] cnt;
        logic          mismatch;
        logic          boundary;
    } t_cmp;

    function automatic t_cmp f_emit(input t_cmp s, input logic [7:0] c,
                                    input logic [CW-1:0] len,
                                    input logic [ROOT_MAX_BYTES-1:0][7:0] root);
        t_cmp v;
        v = s;
        if (s.cnt < len) begin
            if (root[s.cnt[IW-1:0]] != c) begin
                v.mismatch = 1'b1;
            end
        end else if (s.cnt == len) begin
            v.boundary = (c == C_SLASH);
        end
        if (s.cnt <= len) begin
            v.cnt = s.cnt + CW'(1);
        end
        return v;
    endfunction

    logic       r_at_start, n_at_start, s_at_start;
    logic [1:0] r_seg_len, n_seg_len, s_seg_len;
    logic       r_only_dots, n_only_dots, s_only_dots;
    logic       r_dot_held, n_dot_held, s_dot_held;
    logic       r_seg_emitted, n_seg_emitted, s_seg_emitted;
    logic       r_unsafe, n_unsafe, s_unsafe;
    logic       r_dotdot, n_dotdot, s_dotdot;
    t_cmp       r_cmp, n_cmp, s_cmp;
    logic [7:0] c;
    logic       fin_dotdot;

    always_comb begin
        c             = i_item.path_char;
        s_at_start    = r_at_start;
        s_seg_len     = r_seg_len;
        s_only_dots   = r_only_dots;
        s_dot_held    = r_dot_held;
        s_seg_emitted = r_seg_emitted;
        s_unsafe      = r_unsafe;
        s_dotdot      = r_dotdot;
        s_cmp         = r_cmp;

        if (!i_item.no_char) begin
            if (c < C_SAFE_LO || c > C_SAFE_HI) begin
                s_unsafe = 1'b1;
            end
            if (c == C_SLASH) begin
                if (s_at_start) begin
                    s_cmp = f_emit(s_cmp, C_SLASH, i_root_len, i_root);
                end
                if (s_seg_len == 2'd2 && s_only_dots) begin
                    s_dotdot = 1'b1;
                end
                s_seg_len   = 2'd0;
                s_only_dots = 1'b1;
                s_dot_held  = 1'b0;
            end else begin
                if (s_seg_len == 2'd0) begin
                    if (c == C_DOT) begin
                        s_dot_held = 1'b1;
                    end else begin
                        if (s_seg_emitted) begin
                            s_cmp = f_emit(s_cmp, C_SLASH, i_root_len, i_root);
                        end
                        s_cmp         = f_emit(s_cmp, c, i_root_len, i_root);
                        s_seg_emitted = 1'b1;
                    end
                end else if (s_seg_len == 2'd1 && s_dot_held) begin
                    if (s_seg_emitted) begin
                        s_cmp = f_emit(s_cmp, C_SLASH, i_root_len, i_root);
                    end
                    s_cmp         = f_emit(s_cmp, C_DOT, i_root_len, i_root);
                    s_cmp         = f_emit(s_cmp, c, i_root_len, i_root);
                    s_seg_emitted = 1'b1;
                    s_dot_held    = 1'b0;
                end else begin
                    s_cmp = f_emit(s_cmp, c, i_root_len, i_root);
                end
                if (s_seg_len != 2'd3) begin
                    s_seg_len = s_seg_len + 2'd1;
                end
                if (c != C_DOT) begin
                    s_only_dots = 1'b0;
                end
            end
            s_at_start = 1'b0;
        end

        fin_dotdot = s_dotdot || (s_seg_len == 2'd2 && s_only_dots);

        if (s_unsafe) begin
            o_reason = RSN_UNSAFE;
        end else if (fin_dotdot) begin
            o_reason = RSN_DOTDOT;
        end else if (i_root_len == '0) begin
            o_reason = RSN_OUTSIDE;
        end else if (i_root_len == CW'(1) && i_root[0] == C_SLASH) begin
            o_reason = RSN_OK;
        end else if (s_cmp.cnt < i_root_len || s_cmp.mismatch) begin
            o_reason = RSN_OUTSIDE;
        end else if (s_cmp.cnt == i_root_len || s_cmp.boundary) begin
            o_reason = RSN_OK;
        end else begin
            o_reason = RSN_OUTSIDE;
        end

        if (i_item.last_char) begin
            n_at_start    = 1'b1;
            n_seg_len     = 2'd0;
            n_only_dots   = 1'b1;
            n_dot_held    = 1'b0;
            n_seg_emitted = 1'b0;
            n_unsafe      = 1'b0;
            n_dotdot      = 1'b0;
            n_cmp         = '0;
        end else begin
            n_at_start    = s_at_start;
            n_seg_len     = s_seg_len;
            n_only_dots   = s_only_dots;
            n_dot_held    = s_dot_held;
            n_seg_emitted = s_seg_emitted;
            n_unsafe      = s_unsafe;
            n_dotdot      = s_dotdot;
            n_cmp         = s_cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start    <= 1'b1;
            r_seg_len     <= 2'd0;
            r_only_dots   <= 1'b1;
            r_dot_held    <= 1'b0;
            r_seg_emitted <= 1'b0;
            r_unsafe      <= 1'b0;
            r_dotdot      <= 1'b0;
            r_cmp         <= '0;
        end else if (i_step) begin
            r_at_start    <= n_at_start;
            r_seg_len     <= n_seg_len;
            r_only_dots   <= n_only_dots;
            r_dot_held    <= n_dot_held;
            r_seg_emitted <= n_seg_emitted;
            r_unsafe      <= n_unsafe;
            r_dotdot      <= n_dotdot;
            r_cmp         <= n_cmp;
        end
    end

endmodule
